### rtl/hcbp_pkg.sv
// Shared types, constants and CRC/count helpers for the Huffman code bit packer.
`default_nettype none
package hcbp_pkg;

	localparam int CODE_W       = 32;
	localparam int LEN_W        = 6;
	localparam int SYM_W        = 8;
	localparam int CNT_W        = 48;
	localparam int ALPHABET     = 256;
	localparam int QDEPTH       = 4;
	localparam int QAW          = 2;
	localparam int QCW          = 3;

	localparam logic [LEN_W-1:0]  MAX_CODE_LEN = 6'd32;
	localparam logic [CODE_W-1:0] CRC_INIT     = 32'hFFFF_FFFF;
	localparam logic [CODE_W-1:0] CRC_POLY     = 32'hEDB8_8320;
	localparam logic [CNT_W-1:0]  CNT_MAX      = 48'hFFFF_FFFF_FFFF;

	typedef enum logic [1:0] {
		ACT_LOAD   = 2'd0,
		ACT_ENCODE = 2'd1,
		ACT_FLUSH  = 2'd2
	} action_t;

	typedef logic [SYM_W-1:0]  sym_t;
	typedef logic [CODE_W-1:0] code_t;
	typedef logic [LEN_W-1:0]  len_t;
	typedef logic [CNT_W-1:0]  cnt_t;

	// Command between front and back; code is left-aligned (first bit in bit 31).
	typedef struct packed {
		logic  flush;
		code_t code;
		len_t  len;
	} cmd_t;

	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} qport_t;

	function automatic code_t crc_byte(input code_t c, input logic [7:0] b);
		code_t r;
		r = c ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			r = (r >> 1) ^ (CRC_POLY & {CODE_W{r[0]}});
		end
		return r;
	endfunction

	function automatic cnt_t sat_add(input cnt_t c, input logic [3:0] n);
		logic [CNT_W:0] s;
		s = {1'b0, c} + {{(CNT_W-3){1'b0}}, n};
		return s[CNT_W] ? CNT_MAX : s[CNT_W-1:0];
	endfunction

endpackage
`default_nettype wire

### rtl/hcbp_ifs.sv
// Valid/ready channel interfaces for source items and packed results.
`default_nettype none
interface hcbp_item_if;
	logic               valid;
	logic               ready;
	logic [1:0]         action;
	hcbp_pkg::sym_t     symbol;
	hcbp_pkg::code_t    code_bits;
	hcbp_pkg::len_t     code_len;

	modport source (output valid, output action, output symbol, output code_bits,
		output code_len, input ready);
	modport sink (input valid, input action, input symbol, input code_bits,
		input code_len, output ready);
endinterface

interface hcbp_result_if;
	logic               valid;
	logic               ready;
	logic [7:0]         packed_byte;
	logic               byte_valid;
	hcbp_pkg::code_t    crc_value;
	hcbp_pkg::cnt_t     bit_total;
	logic               last;

	modport source (output valid, output packed_byte, output byte_valid,
		output crc_value, output bit_total, output last, input ready);
	modport sink (input valid, input packed_byte, input byte_valid,
		input crc_value, input bit_total, input last, output ready);
endinterface
`default_nettype wire

### rtl/hcbp_front.sv
// Front end: accepts items, owns the code store, turns encodes and flushes into commands.
`default_nettype none
module hcbp_front (
	input  wire logic        clk,
	input  wire logic        arst_n,
	hcbp_item_if.sink        item,
	output hcbp_pkg::qport_t push,
	input  wire logic        q_full
);
	import hcbp_pkg::*;

	logic [CODE_W+LEN_W-1:0] store [ALPHABET];
	logic [CODE_W+LEN_W-1:0] rd_s1;
	logic                    valid_s1;
	logic                    flush_s1;

	logic     accept;
	logic     is_load;
	logic     is_cmd;
	len_t     ld_len;
	code_t    rd_code;
	len_t     rd_len;
	len_t     sh_amt;

	assign item.ready = !valid_s1 || !q_full;
	assign accept     = item.valid && item.ready;
	assign is_load    = (item.action == ACT_LOAD);
	assign is_cmd     = (item.action == ACT_ENCODE) || (item.action == ACT_FLUSH);
	assign ld_len     = (item.code_len > MAX_CODE_LEN) ? MAX_CODE_LEN : item.code_len;

	assign rd_code = rd_s1[CODE_W-1:0];
	assign rd_len  = rd_s1[CODE_W+LEN_W-1:CODE_W];
	assign sh_amt  = len_t'(CODE_W) - rd_len;

	// Empty codes are dropped here; they produce nothing downstream.
	always_comb begin
		push.valid     = valid_s1 && !q_full && (flush_s1 || rd_len != '0);
		push.cmd.flush = flush_s1;
		push.cmd.code  = rd_code << sh_amt[4:0];
		push.cmd.len   = rd_len;
	end

	always_ff @(posedge clk) begin
		if (accept && is_load) begin
			store[item.symbol] <= {ld_len, item.code_bits};
		end
		if (accept && item.action == ACT_ENCODE) begin
			rd_s1 <= store[item.symbol];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			flush_s1 <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= is_cmd;
				flush_s1 <= (item.action == ACT_FLUSH);
			end else if (!q_full) begin
				valid_s1 <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

### rtl/hcbp_queue.sv
// Small command FIFO decoupling the front end from the bit packer.
`default_nettype none
module hcbp_queue (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire hcbp_pkg::qport_t push,
	output logic                  full,
	output hcbp_pkg::qport_t      head,
	input  wire logic             pop
);
	import hcbp_pkg::*;

	cmd_t             mem_q [QDEPTH];
	logic [QAW-1:0]   wr_q;
	logic [QAW-1:0]   rd_q;
	logic [QCW-1:0]   cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full       = (cnt_q == QCW'(QDEPTH));
	assign head.valid = (cnt_q != '0);
	assign head.cmd   = mem_q[rd_q];
	assign do_push    = push.valid && !full;
	assign do_pop     = pop && head.valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push.cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wr_q <= wr_q + 1'b1;
			if (do_pop)  rd_q <= rd_q + 1'b1;
			if (do_push && !do_pop)      cnt_q <= cnt_q + 1'b1;
			else if (!do_push && do_pop) cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule
`default_nettype wire

### rtl/hcbp_back.sv
// Back end: packs code bits into bytes, keeps CRC and bit count, drives the result register.
`default_nettype none
module hcbp_back (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire hcbp_pkg::qport_t head,
	output logic                  pop,
	hcbp_result_if.source         result
);
	import hcbp_pkg::*;

	typedef enum logic {ST_IDLE, ST_ENC} state_t;

	state_t      state_q;
	logic [7:0]  pend_q;
	logic [2:0]  used_q;
	code_t       crc_q;
	cnt_t        cnt_q;
	code_t       sh_q;
	len_t        rem_q;
	logic        ov_q;
	logic [7:0]  byte_q;
	logic        bvalid_q;
	code_t       ocrc_q;
	cnt_t        ocnt_q;
	logic        last_q;

	logic        out_free;
	logic [3:0]  avail;
	logic [7:0]  merged;
	logic        full_byte;
	logic [7:0]  crc_in;
	code_t       crc_nx;
	logic [3:0]  add_n;
	cnt_t        cnt_nx;
	len_t        rem_after;
	logic        emit;

	assign out_free  = !ov_q || result.ready;
	assign avail     = 4'd8 - {1'b0, used_q};
	assign merged    = pend_q | (sh_q[31:24] >> used_q);
	assign full_byte = ({2'b00, avail} <= rem_q);
	assign rem_after = rem_q - {2'b00, avail};
	assign crc_in    = (state_q == ST_ENC) ? merged : pend_q;
	assign crc_nx    = crc_byte(crc_q, crc_in);
	assign add_n     = (state_q == ST_ENC) ? 4'd8 : {1'b0, used_q};
	assign cnt_nx    = sat_add(cnt_q, add_n);
	assign pop       = (state_q == ST_IDLE) && head.valid && (!head.cmd.flush || out_free);
	assign emit      = ((state_q == ST_IDLE) && pop && head.cmd.flush) ||
		((state_q == ST_ENC) && full_byte && out_free);

	assign result.valid       = ov_q;
	assign result.packed_byte = byte_q;
	assign result.byte_valid  = bvalid_q;
	assign result.crc_value   = ocrc_q;
	assign result.bit_total   = ocnt_q;
	assign result.last        = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			pend_q   <= '0;
			used_q   <= '0;
			crc_q    <= CRC_INIT;
			cnt_q    <= '0;
			sh_q     <= '0;
			rem_q    <= '0;
			ov_q     <= 1'b0;
			byte_q   <= '0;
			bvalid_q <= 1'b0;
			ocrc_q   <= '0;
			ocnt_q   <= '0;
			last_q   <= 1'b0;
		end else begin
			if (emit) ov_q <= 1'b1;
			else if (result.ready) ov_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (pop && head.cmd.flush) begin
						last_q   <= 1'b1;
						bvalid_q <= (used_q != '0);
						byte_q   <= (used_q != '0) ? pend_q : 8'd0;
						ocrc_q   <= (used_q != '0) ? crc_nx : crc_q;
						ocnt_q   <= (used_q != '0) ? cnt_nx : cnt_q;
						pend_q   <= '0;
						used_q   <= '0;
						crc_q    <= CRC_INIT;
						cnt_q    <= '0;
					end else if (pop) begin
						sh_q    <= head.cmd.code;
						rem_q   <= head.cmd.len;
						state_q <= ST_ENC;
					end
				end
				ST_ENC: begin
					if (full_byte) begin
						if (out_free) begin
							byte_q   <= merged;
							bvalid_q <= 1'b1;
							ocrc_q   <= crc_nx;
							ocnt_q   <= cnt_nx;
							// last once the leftover bits cannot fill another byte
							last_q   <= (rem_after < 6'd8);
							crc_q    <= crc_nx;
							cnt_q    <= cnt_nx;
							pend_q   <= '0;
							used_q   <= '0;
							sh_q     <= sh_q << avail;
							rem_q    <= rem_after;
							if (rem_after == '0) state_q <= ST_IDLE;
						end
					end else begin
						pend_q  <= merged;
						used_q  <= used_q + rem_q[2:0];
						rem_q   <= '0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

### rtl/huffman_code_bit_packer_core.sv
// Top level of the Huffman code bit packer: front end, command queue and bit packer.
//
//  channel  | role   | payload
//  ---------+--------+-------------------------------------------------------
//  item     | sink   | action, symbol, code_bits, code_len
//  result   | source | packed_byte, byte_valid, crc_value, bit_total, last
//
// A load is absorbed by the front end and yields nothing. An encode passes the front
// stage and the queue; the packer dequeues it and emits its bytes while the result
// register is free, keeping leftover bits pending; a flush emits on dequeue.
// The code store has no reset and must be loaded before its entries are encoded.
// A four-entry command queue lets the front keep accepting while the packer waits on
// a stalled result register; the front stalls only when that queue is full.
`default_nettype none
module huffman_code_bit_packer_core (
	input  wire logic     clk,
	input  wire logic     arst_n,
	hcbp_item_if.sink     item,
	hcbp_result_if.source result
);
	import hcbp_pkg::*;

	qport_t push;
	qport_t head;
	logic   q_full;
	logic   pop;

	hcbp_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.push   (push),
		.q_full (q_full)
	);

	hcbp_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (q_full),
		.head   (head),
		.pop    (pop)
	);

	hcbp_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.pop    (pop),
		.result (result)
	);

endmodule
`default_nettype wire
